// ----- hw/rtl/thfi_pkg.sv -----
package thfi_pkg;

	localparam int NODE_W  = 12;
	localparam int KIND_W  = 3;
	localparam int WORD_W  = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SCALE = 3'd6;

	typedef struct packed {
		logic                     cmd;
		logic [NODE_W-1:0]        node_index;
		logic [KIND_W-1:0]        coef_kind;
		logic signed [WORD_W-1:0] coef_x;
		logic signed [WORD_W-1:0] coef_y;
		logic signed [WORD_W-1:0] coef_z;
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] field_x;
		logic signed [WORD_W-1:0] field_y;
		logic signed [WORD_W-1:0] field_z;
		logic                     in_grid;
	} out_item_t;

	// coefficient kind -> derivative axes {z,y,x}
	function automatic logic [2:0] deriv_bits(input logic [2:0] kind);
		logic [2:0] r;
		case (kind)
			3'd0: r = 3'd0;
			3'd1: r = 3'd1;
			3'd2: r = 3'd2;
			3'd3: r = 3'd4;
			3'd4: r = 3'd3;
			3'd5: r = 3'd5;
			3'd6: r = 3'd6;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	// derivative axes {z,y,x} -> coefficient kind
	function automatic logic [2:0] kind_of_bits(input logic [2:0] bits);
		logic [2:0] r;
		case (bits)
			3'd0: r = 3'd0;
			3'd1: r = 3'd1;
			3'd2: r = 3'd2;
			3'd3: r = 3'd4;
			3'd4: r = 3'd3;
			3'd5: r = 3'd5;
			3'd6: r = 3'd6;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/thfi_div.sv -----
// Restoring divider, one quotient bit per cycle. Only the low QW quotient bits are kept.
module thfi_div #(
	parameter int DW = 48,
	parameter int QW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [30:0]   divisor,
	output logic          done,
	output logic [QW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] num_q;
	logic [30:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [31:0] trial;
	logic        ge;
	logic [31:0] diff;

	assign trial = {rem_q, num_q[DW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			rem_q <= ge ? diff[30:0] : trial[30:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/tricubic_hermite_field_interp.sv -----
// Tricubic Hermite interpolator for a three-component field on an NX x NY x NZ grid,
// Q16.16 by default. One item at a time: a load (cmd 0) scales one coefficient word by
// its spacings and field_scale and writes it to the coefficient store. A query (cmd 1)
// runs the grid test, the bit-serial dividers that give box and fraction, basis
// evaluation, 64 reads from the single-port 32768 x 96 coefficient store (one word per
// cycle), a drain of the read pipeline and the result step. A point off the grid
// returns zeros with in_grid clear. The result sits in an output register; the next
// item is taken while it waits. Store entries never written read as garbage and must
// not be queried. Configuration writes are taken in any cycle and must only be issued
// while the block is idle.
module tricubic_hermite_field_interp #(
	parameter int NX        = 16,
	parameter int NY        = 16,
	parameter int NZ        = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  thfi_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output thfi_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int F    = FRAC_BITS;
	localparam int HW   = F + 3;         // basis values, fractions
	localparam int P1W  = 32 + HW;       // coef * basis
	localparam int TBW  = P1W + 2;       // sum of four
	localparam int TBRW = TBW - F;       // rounded sum
	localparam int P2W  = TBRW + HW;     // rounded sum * tf
	localparam int AW   = P2W + 4;       // sum of sixteen
	localparam int RW   = AW - F;
	localparam int DW   = 32 + F;
	localparam int QW   = F + 8;
	localparam int LIMW = 39;

	localparam logic [11:0] STEP_Y = 12'(NX % 4096);
	localparam logic [11:0] STEP_Z = 12'((NX * NY) % 4096);

	localparam logic signed [HW-1:0]    ONE_H   = HW'(1 << F);
	localparam logic signed [HW-1:0]    THREE_H = HW'(3 << F);
	localparam logic signed [2*HW-1:0]  HALF_H  = (2*HW)'(1 << (F - 1));
	localparam logic signed [TBW-1:0]   HALF_TB = TBW'(1 << (F - 1));
	localparam logic signed [AW-1:0]    HALF_A  = AW'(1 << (F - 1));
	localparam logic signed [63:0]      HALF_64 = 64'(1 << (F - 1));
	localparam logic signed [RW-1:0]    MAX_R   = RW'(32'h7fff_ffff);
	localparam logic signed [RW-1:0]    MIN_R   = -MAX_R - RW'(1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LDMUL = 4'd1;
	localparam logic [3:0] ST_LDWR  = 4'd2;
	localparam logic [3:0] ST_CHK   = 4'd3;
	localparam logic [3:0] ST_DIV   = 4'd4;
	localparam logic [3:0] ST_BASA  = 4'd5;
	localparam logic [3:0] ST_BASB  = 4'd6;
	localparam logic [3:0] ST_RUN   = 4'd7;
	localparam logic [3:0] ST_DRAIN = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	function automatic logic signed [HW-1:0] rmul_h(input logic signed [HW-1:0] a,
			input logic signed [HW-1:0] b);
		logic signed [2*HW-1:0] p;
		logic signed [2*HW-1:0] r;
		p = a * b;
		r = (p + HALF_H) >>> F;
		return r[HW-1:0];
	endfunction

	// load scaling: sat32(round(w * s / 2^F))
	function automatic logic signed [31:0] rmul_sat(input logic signed [31:0] w,
			input logic [30:0] s);
		logic signed [63:0] p;
		logic signed [63:0] r;
		logic signed [31:0] o;
		p = $signed({{32{w[31]}}, w}) * $signed({33'b0, s});
		r = (p + HALF_64) >>> F;
		if (r > 64'sh7fff_ffff)
			o = 32'sh7fff_ffff;
		else if (r < -64'sh8000_0000)
			o = -32'sh8000_0000;
		else
			o = r[31:0];
		return o;
	endfunction

	// ---------------- configuration ----------------
	logic signed [31:0] org_q [3];
	logic [30:0]        sp_q  [3];
	logic [30:0]        scale_q;
	logic [30:0]        s_eff [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			sp_q[0]  <= 31'd65536;
			sp_q[1]  <= 31'd65536;
			sp_q[2]  <= 31'd65536;
			scale_q  <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				thfi_pkg::CFG_ORIGIN_X:    org_q[0] <= cfg_data;
				thfi_pkg::CFG_ORIGIN_Y:    org_q[1] <= cfg_data;
				thfi_pkg::CFG_ORIGIN_Z:    org_q[2] <= cfg_data;
				thfi_pkg::CFG_SPACING_X:   sp_q[0]  <= cfg_data[30:0];
				thfi_pkg::CFG_SPACING_Y:   sp_q[1]  <= cfg_data[30:0];
				thfi_pkg::CFG_SPACING_Z:   sp_q[2]  <= cfg_data[30:0];
				thfi_pkg::CFG_FIELD_SCALE: scale_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// zero spacing acts as one LSB
	always_comb begin
		for (int a = 0; a < 3; a++)
			s_eff[a] = (sp_q[a] == '0) ? 31'd1 : sp_q[a];
	end

	// ---------------- control ----------------
	logic [3:0] state_q;
	logic [1:0] step_q;
	logic [5:0] j_q;
	logic       v_s1, v_s2, v_s3, v_s4;
	logic       fin_go_q;
	logic       out_valid_q;
	logic       in_take;
	logic       out_free;

	thfi_pkg::in_item_t  item_q;
	thfi_pkg::out_item_t out_data_q;

	logic signed [31:0] w_q [3];
	logic signed [32:0] d_q [3];
	logic [7:0]         box_q [3];
	logic signed [HW-1:0] t_q  [3];
	logic signed [HW-1:0] tt_q [3];
	logic signed [HW-1:0] uu_q [3];
	logic signed [HW-1:0] u_w  [3];
	logic signed [HW-1:0] h_q  [3][4];
	logic [11:0]        base_q;
	logic               in_grid_q;

	logic [2:0]  ld_bits;
	logic [30:0] ld_s;
	logic        ld_en;

	logic        outside_ax [3];
	logic        outside_any;
	logic        div_start;
	logic [2:0]  div_done_ax;
	logic        div_done;
	logic [7:0]  box_n [3];
	logic signed [HW-1:0] t_n [3];

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign ld_bits = thfi_pkg::deriv_bits(item_q.coef_kind);

	always_comb begin
		case (step_q)
			2'd0: begin
				ld_s  = s_eff[0];
				ld_en = ld_bits[0];
			end
			2'd1: begin
				ld_s  = s_eff[1];
				ld_en = ld_bits[1];
			end
			2'd2: begin
				ld_s  = s_eff[2];
				ld_en = ld_bits[2];
			end
			default: begin
				ld_s  = scale_q;
				ld_en = 1'b1;
			end
		endcase
	end

	// ---------------- per-axis locate ----------------
	for (genvar a = 0; a < 3; a++) begin : gen_ax
		localparam int NA = (a == 0) ? NX : (a == 1) ? NY : NZ;

		logic [LIMW-1:0] lim;
		logic [QW-1:0]   quo;
		logic [7:0]      ix;

		assign lim = LIMW'(NA - 1) * LIMW'(s_eff[a]);
		assign outside_ax[a] = d_q[a][32] || (LIMW'(d_q[a][31:0]) > lim);

		// floor(d * 2^F / s) = box * 2^F + fraction
		thfi_div #(.DW(DW), .QW(QW)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend ({d_q[a][31:0], {F{1'b0}}}),
			.divisor  (s_eff[a]),
			.done     (div_done_ax[a]),
			.quotient (quo)
		);

		assign ix = quo[QW-1:F];

		// on the upper plane: last box, fraction one
		always_comb begin
			if (ix >= 8'(NA - 1)) begin
				box_n[a] = 8'(NA - 2);
				t_n[a]   = ONE_H;
			end else begin
				box_n[a] = ix;
				t_n[a]   = $signed({3'b000, quo[F-1:0]});
			end
		end

		assign u_w[a] = t_q[a] - ONE_H;
	end

	assign outside_any = outside_ax[0] || outside_ax[1] || outside_ax[2];
	assign div_start   = (state_q == ST_CHK) && !outside_any;
	assign div_done    = &div_done_ax;

	// ---------------- coefficient store ----------------
	logic [95:0] mem [0:32767];
	logic [95:0] rdata_q;
	logic        mem_we;
	logic        mem_re;
	logic [14:0] mem_addr;
	logic [11:0] rd_node;
	logic [2:0]  rd_kind;

	assign mem_we = (state_q == ST_LDWR);
	assign mem_re = (state_q == ST_RUN);

	// j = {m, q, k}: z basis, y basis, x basis
	assign rd_node = base_q + (j_q[1] ? 12'd1 : 12'd0) + (j_q[3] ? STEP_Y : 12'd0)
		+ (j_q[5] ? STEP_Z : 12'd0);
	assign rd_kind = thfi_pkg::kind_of_bits({j_q[4], j_q[2], j_q[0]});
	assign mem_addr = mem_we ? {item_q.node_index, item_q.coef_kind} : {rd_node, rd_kind};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= {w_q[2], w_q[1], w_q[0]};
		else if (mem_re)
			rdata_q <= mem[mem_addr];
	end

	// ---------------- FSM ----------------
	logic [5:0] j_s1, j_s2;
	logic       last_s3, last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			j_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			fin_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1     <= mem_re;
			v_s2     <= v_s1;
			v_s3     <= v_s2 && (j_s2[1:0] == 2'd3);
			v_s4     <= v_s3;
			fin_go_q <= v_s4 && last_s4;
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						step_q  <= '0;
						state_q <= (in_data.cmd == thfi_pkg::CMD_LOAD) ? ST_LDMUL : ST_CHK;
					end
				end
				ST_LDMUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3)
						state_q <= ST_LDWR;
				end
				ST_LDWR: state_q <= ST_IDLE;
				ST_CHK:  state_q <= outside_any ? ST_FIN : ST_DIV;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_BASA;
				end
				ST_BASA: state_q <= ST_BASB;
				ST_BASB: begin
					j_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					j_q <= j_q + 1'b1;
					if (j_q == 6'd63)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (fin_go_q)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	logic signed [31:0]     coef_s1 [3];
	logic signed [P1W-1:0]  prod_s2 [3];
	logic signed [HW-1:0]   tf_s2, tf_s3;
	logic signed [TBW-1:0]  tb_q    [3];
	logic signed [TBW-1:0]  tb_sum  [3];
	logic signed [TBW-1:0]  tb_rnd  [3];
	logic signed [TBRW-1:0] tbr_s3  [3];
	logic signed [P2W-1:0]  p2_s4   [3];
	logic signed [AW-1:0]   acc_q   [3];
	logic signed [AW-1:0]   acc_rnd [3];
	logic signed [31:0]     res_w   [3];

	assign coef_s1[0] = rdata_q[31:0];
	assign coef_s1[1] = rdata_q[63:32];
	assign coef_s1[2] = rdata_q[95:64];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			tb_sum[c]  = tb_q[c] + TBW'(prod_s2[c]);
			tb_rnd[c]  = (tb_sum[c] + HALF_TB) >>> F;
			acc_rnd[c] = (acc_q[c] + HALF_A) >>> F;
			if ($signed(acc_rnd[c][RW-1:0]) > MAX_R)
				res_w[c] = 32'sh7fff_ffff;
			else if ($signed(acc_rnd[c][RW-1:0]) < MIN_R)
				res_w[c] = -32'sh8000_0000;
			else
				res_w[c] = acc_rnd[c][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q <= in_data;
			w_q[0] <= in_data.coef_x;
			w_q[1] <= in_data.coef_y;
			w_q[2] <= in_data.coef_z;
			d_q[0] <= $signed({in_data.pos_x[31], in_data.pos_x}) - $signed({org_q[0][31], org_q[0]});
			d_q[1] <= $signed({in_data.pos_y[31], in_data.pos_y}) - $signed({org_q[1][31], org_q[1]});
			d_q[2] <= $signed({in_data.pos_z[31], in_data.pos_z}) - $signed({org_q[2][31], org_q[2]});
		end
		if (state_q == ST_LDMUL && ld_en) begin
			for (int c = 0; c < 3; c++)
				w_q[c] <= rmul_sat(w_q[c], ld_s);
		end
		if (state_q == ST_CHK) begin
			in_grid_q <= !outside_any;
			for (int c = 0; c < 3; c++)
				acc_q[c] <= '0;
		end
		if (div_done) begin
			for (int a = 0; a < 3; a++) begin
				box_q[a] <= box_n[a];
				t_q[a]   <= t_n[a];
			end
		end
		if (state_q == ST_BASA) begin
			for (int a = 0; a < 3; a++) begin
				tt_q[a] <= rmul_h(t_q[a], t_q[a]);
				uu_q[a] <= rmul_h(u_w[a], u_w[a]);
			end
			base_q <= 12'(32'(box_q[0]) + NX * (32'(box_q[1]) + NY * 32'(box_q[2])));
		end
		if (state_q == ST_BASB) begin
			for (int a = 0; a < 3; a++) begin
				h_q[a][0] <= rmul_h(uu_q[a], ONE_H + (t_q[a] <<< 1));
				h_q[a][1] <= rmul_h(uu_q[a], t_q[a]);
				h_q[a][2] <= rmul_h(tt_q[a], THREE_H - (t_q[a] <<< 1));
				h_q[a][3] <= rmul_h(u_w[a], tt_q[a]);
			end
		end

		// s1: read data back; coef * fx[k], tf = fy[q] * fz[m]
		j_s1 <= j_q;
		j_s2 <= j_s1;
		for (int c = 0; c < 3; c++)
			prod_s2[c] <= coef_s1[c] * h_q[0][j_s1[1:0]];
		tf_s2 <= rmul_h(h_q[1][j_s1[3:2]], h_q[2][j_s1[5:4]]);

		// s2: exact sum of four, rounded once
		if (v_s2) begin
			for (int c = 0; c < 3; c++)
				tb_q[c] <= (j_s2[1:0] == 2'd0) ? TBW'(prod_s2[c]) : tb_sum[c];
		end
		for (int c = 0; c < 3; c++)
			tbr_s3[c] <= tb_rnd[c][TBRW-1:0];
		tf_s3   <= tf_s2;
		last_s3 <= (j_s2 == 6'd63);

		// s3: times tf
		for (int c = 0; c < 3; c++)
			p2_s4[c] <= tbr_s3[c] * tf_s3;
		last_s4 <= last_s3;

		// s4: accumulate
		if (v_s4) begin
			for (int c = 0; c < 3; c++)
				acc_q[c] <= acc_q[c] + AW'(p2_s4[c]);
		end

		if (state_q == ST_FIN && out_free) begin
			if (in_grid_q) begin
				out_data_q.field_x <= res_w[0];
				out_data_q.field_y <= res_w[1];
				out_data_q.field_z <= res_w[2];
				out_data_q.in_grid <= 1'b1;
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------- checks ----------------
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_wr_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !v_s1 && !v_s2 && !v_s4)
		else $error("store write while the read pipeline is busy");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the result phase");

endmodule

// ----- bench/tb.sv -----
module tb;

	// grid size and fixed point format of the instance under test
	localparam int GRID_N    = 16;
	localparam int FRAC      = 16;
	localparam longint ONE   = 64'sd1 << FRAC;
	localparam int MAX_IDLE  = 17;
	// cycles to let a trailing load settle before touching the registers
	localparam int SETTLE    = 200;
	// coefficient kind for each combination of derivative axes {z,y,x}
	localparam logic [2:0] AXES_TO_KIND [8] = '{3'd0, 3'd1, 3'd2, 3'd4,
		3'd3, 3'd5, 3'd6, 3'd7};
	// derivative axes {z,y,x} carried by each coefficient kind
	localparam logic [2:0] KIND_AXES [8] = '{3'd0, 3'd1, 3'd2, 3'd4,
		3'd3, 3'd5, 3'd6, 3'd7};

	typedef longint quad_t [4];

	// an input item plus, for directed rows, a hand-written expected result
	typedef struct {
		thfi_pkg::in_item_t  item;
		bit                  typed;
		thfi_pkg::out_item_t res;
	} stim_row_t;

	typedef struct {
		bit                  typed;
		thfi_pkg::out_item_t res;
	} typed_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	thfi_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	thfi_pkg::out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	tricubic_hermite_field_interp u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Shadow copy of the block: registers and the scaled coefficient table
	// ---------------------------------------------------------------------
	longint org_x, org_y, org_z;
	longint spc_x, spc_y, spc_z;
	longint fscale;
	int     coef_mem [GRID_N*GRID_N*GRID_N][8][3];
	// entries the stimulus has already loaded (tracked when items are made)
	bit     loaded [GRID_N*GRID_N*GRID_N][8];

	thfi_pkg::out_item_t field_q [$];   // interpolated fields still owed by the block
	typed_t    typed_q [$];   // per item in flight: hand-written result if any
	int        err_cnt;
	int        sent_cnt;      // input transfers so far
	bit        burst;         // no idling on either side while set

	function automatic longint rnd_shift(longint v);
		return (v + (64'sd1 << (FRAC-1))) >>> FRAC;
	endfunction

	function automatic longint fxmul(longint a, longint b);
		return rnd_shift(a * b);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint eff_spc(longint s);
		return (s == 0) ? 64'sd1 : s;
	endfunction

	// box index and fraction along one axis; 0 when the point is off the grid
	function automatic bit find_box(longint pos, longint org, longint sp,
			output longint box, output longint t);
		longint d, s, ix;
		d = pos - org;
		s = eff_spc(sp);
		box = 0;
		t = 0;
		if (d < 0 || d > (GRID_N-1) * s)
			return 1'b0;
		ix = d / s;
		if (ix >= GRID_N-1) begin
			// exactly on the last plane: last box, fraction one
			box = GRID_N-2;
			t = ONE;
		end else begin
			box = ix;
			t = ((d - ix*s) << FRAC) / s;
		end
		return 1'b1;
	endfunction

	function automatic quad_t hermite(longint t);
		quad_t h;
		longint u, tt, uu;
		u  = t - ONE;
		tt = fxmul(t, t);
		uu = fxmul(u, u);
		h[0] = fxmul(uu, ONE + 2*t);
		h[1] = fxmul(uu, t);
		h[2] = fxmul(tt, 3*ONE - 2*t);
		h[3] = fxmul(u, tt);
		return h;
	endfunction

	function automatic void store_coef(thfi_pkg::in_item_t it);
		longint w;
		logic [2:0] ax;
		ax = KIND_AXES[it.coef_kind];
		for (int c = 0; c < 3; c++) begin
			w = (c == 0) ? longint'(it.coef_x) : (c == 1) ? longint'(it.coef_y)
				: longint'(it.coef_z);
			if (ax[0]) w = sat32(fxmul(w, eff_spc(spc_x)));
			if (ax[1]) w = sat32(fxmul(w, eff_spc(spc_y)));
			if (ax[2]) w = sat32(fxmul(w, eff_spc(spc_z)));
			w = sat32(fxmul(w, fscale));
			coef_mem[it.node_index][it.coef_kind][c] = int'(w);
		end
	endfunction

	function automatic thfi_pkg::out_item_t interp_field(thfi_pkg::in_item_t it);
		thfi_pkg::out_item_t r;
		longint bx, by, bz, tx, ty, tz, tf, node;
		longint acc [3];
		longint part [3];
		quad_t fx, fy, fz;
		logic [2:0] kind;
		r = '0;
		if (!find_box(it.pos_x, org_x, spc_x, bx, tx) ||
				!find_box(it.pos_y, org_y, spc_y, by, ty) ||
				!find_box(it.pos_z, org_z, spc_z, bz, tz))
			return r;
		fx = hermite(tx);
		fy = hermite(ty);
		fz = hermite(tz);
		acc = '{0, 0, 0};
		for (int m = 0; m < 4; m++) begin
			for (int q = 0; q < 4; q++) begin
				tf = fxmul(fy[q], fz[m]);
				part = '{0, 0, 0};
				for (int k = 0; k < 4; k++) begin
					node = (bx + (k >> 1)) + GRID_N * ((by + (q >> 1))
						+ GRID_N * (bz + (m >> 1)));
					kind = AXES_TO_KIND[{m[0], q[0], k[0]}];
					for (int c = 0; c < 3; c++)
						part[c] += longint'(coef_mem[node & 4095][kind][c]) * fx[k];
				end
				for (int c = 0; c < 3; c++)
					acc[c] += rnd_shift(part[c]) * tf;
			end
		end
		r.field_x = 32'(sat32(rnd_shift(acc[0])));
		r.field_y = 32'(sat32(rnd_shift(acc[1])));
		r.field_z = 32'(sat32(rnd_shift(acc[2])));
		r.in_grid = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		err_cnt++;
	endtask

	function automatic int pick_idle();
		return burst ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// ---------------------------------------------------------------------
	// Input side: every accepted transfer updates the shadow model
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		typed_t tr;
		if (arst_n && in_valid && in_ready) begin
			tr = typed_q.pop_front();
			if (in_data.cmd == thfi_pkg::CMD_LOAD)
				store_coef(in_data);
			else
				field_q.push_back(tr.typed ? tr.res : interp_field(in_data));
		end
	end

	// ---------------------------------------------------------------------
	// Output side: random stalls, compare against the oldest expectation
	// ---------------------------------------------------------------------
	int stall_left;
	always @(posedge clk) begin
		thfi_pkg::out_item_t want;
		if (!arst_n) begin
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (field_q.size() == 0) begin
					report_mismatch("unexpected transfer, in_grid", out_data.in_grid, 0);
				end else begin
					want = field_q.pop_front();
					if (out_data.field_x !== want.field_x)
						report_mismatch("field_x", out_data.field_x, want.field_x);
					if (out_data.field_y !== want.field_y)
						report_mismatch("field_y", out_data.field_y, want.field_y);
					if (out_data.field_z !== want.field_z)
						report_mismatch("field_z", out_data.field_z, want.field_z);
					if (out_data.in_grid !== want.in_grid)
						report_mismatch("in_grid", out_data.in_grid, want.in_grid);
				end
				stall_left = pick_idle();
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
		end
	end

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------
	// valid is left high after a transfer; it drops only when a gap follows
	task automatic send_item(thfi_pkg::in_item_t it, bit typed = 1'b0,
			thfi_pkg::out_item_t res = '0);
		typed_t tr;
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tr.typed = typed;
		tr.res = res;
		typed_q.push_back(tr);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sent_cnt++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		// shadow register update; an unknown index is dropped
		case (idx)
			thfi_pkg::CFG_ORIGIN_X:    org_x = longint'($signed(val));
			thfi_pkg::CFG_ORIGIN_Y:    org_y = longint'($signed(val));
			thfi_pkg::CFG_ORIGIN_Z:    org_z = longint'($signed(val));
			thfi_pkg::CFG_SPACING_X:   spc_x = longint'(val[30:0]);
			thfi_pkg::CFG_SPACING_Y:   spc_y = longint'(val[30:0]);
			thfi_pkg::CFG_SPACING_Z:   spc_z = longint'(val[30:0]);
			thfi_pkg::CFG_FIELD_SCALE: fscale = longint'(val[30:0]);
			default: ;
		endcase
	endtask

	// wait until the block has drained everything it owes
	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		wait (field_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------------
	function automatic logic [31:0] rand_word();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(0, 32'h40000) - 32'h20000;
	endfunction

	function automatic thfi_pkg::in_item_t mk_load(int node, int kind,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
		thfi_pkg::in_item_t it;
		it.cmd        = thfi_pkg::CMD_LOAD;
		it.node_index = 12'(node);
		it.coef_kind  = 3'(kind);
		it.coef_x     = cx;
		it.coef_y     = cy;
		it.coef_z     = cz;
		it.pos_x      = $urandom;
		it.pos_y      = $urandom;
		it.pos_z      = $urandom;
		return it;
	endfunction

	function automatic thfi_pkg::in_item_t mk_query(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		thfi_pkg::in_item_t it;
		it.cmd        = thfi_pkg::CMD_QUERY;
		it.node_index = 12'($urandom);
		it.coef_kind  = 3'($urandom);
		it.coef_x     = $urandom;
		it.coef_y     = $urandom;
		it.coef_z     = $urandom;
		it.pos_x      = px;
		it.pos_y      = py;
		it.pos_z      = pz;
		return it;
	endfunction

	task automatic send_load(thfi_pkg::in_item_t it);
		loaded[it.node_index][it.coef_kind] = 1'b1;
		send_item(it);
	endtask

	// before a query, load every table entry it will read that is still empty
	task automatic send_query(thfi_pkg::in_item_t it, bit typed = 1'b0,
			thfi_pkg::out_item_t res = '0);
		longint bx, by, bz, t;
		int node;
		if (find_box(it.pos_x, org_x, spc_x, bx, t) &&
				find_box(it.pos_y, org_y, spc_y, by, t) &&
				find_box(it.pos_z, org_z, spc_z, bz, t)) begin
			for (int n = 0; n < 8; n++) begin
				node = int'((bx + n[0]) + GRID_N * ((by + n[1]) + GRID_N * (bz + n[2])));
				for (int k = 0; k < 8; k++)
					if (!loaded[node][k])
						send_load(mk_load(node, k, rand_word(), rand_word(), rand_word()));
			end
		end
		send_item(it, typed, res);
	endtask

	// one coordinate: mostly on the grid near its low corner, sometimes off it
	function automatic logic [31:0] rand_coord(longint org, longint sp);
		longint s, off;
		s = eff_spc(sp);
		case ($urandom_range(0, 9))
			0: off = -1 - $urandom_range(0, 1000);
			1: off = (GRID_N-1) * s + 1 + $urandom_range(0, 1000);
			2: off = (GRID_N-1) * s;
			3: off = 0;
			4: return $urandom;
			5: off = longint'($urandom_range(0, GRID_N-2)) * s
				+ $urandom_range(0, s-1);
			default: off = longint'($urandom_range(0, 1)) * s + $urandom_range(0, s-1);
		endcase
		return 32'(org + off);
	endfunction

	// count is the number of input transfers, table fills included
	task automatic random_phase(int count);
		int node;
		int start;
		int i;
		start = sent_cnt;
		i = 0;
		while (sent_cnt - start < count) begin
			if (i % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 55) begin
				send_query(mk_query(rand_coord(org_x, spc_x), rand_coord(org_y, spc_y),
					rand_coord(org_z, spc_z)));
			end else begin
				if ($urandom_range(0, 2) == 0)
					node = $urandom_range(0, 4095);
				else
					node = $urandom_range(0, 2) + GRID_N * ($urandom_range(0, 2)
						+ GRID_N * $urandom_range(0, 2));
				send_load(mk_load(node, $urandom_range(0, 7), rand_word(), rand_word(),
					rand_word()));
			end
			i++;
		end
		burst = 1'b0;
		drain();
	endtask

	task automatic write_all(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [31:0] fs);
		write_reg(thfi_pkg::CFG_ORIGIN_X, ox);
		write_reg(thfi_pkg::CFG_ORIGIN_Y, oy);
		write_reg(thfi_pkg::CFG_ORIGIN_Z, oz);
		write_reg(thfi_pkg::CFG_SPACING_X, sx);
		write_reg(thfi_pkg::CFG_SPACING_Y, sy);
		write_reg(thfi_pkg::CFG_SPACING_Z, sz);
		write_reg(thfi_pkg::CFG_FIELD_SCALE, fs);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	stim_row_t dir_rows [$];

	initial begin
		stim_row_t row;
		thfi_pkg::out_item_t off_grid;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		err_cnt   = 0;
		sent_cnt  = 0;
		burst     = 1'b0;
		org_x = 0; org_y = 0; org_z = 0;
		spc_x = ONE; spc_y = ONE; spc_z = ONE;
		fscale = ONE;
		off_grid = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset settings (unit spacing, origin zero)
		row.typed = 1'b0;
		row.res = '0;
		row.item = mk_load(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		dir_rows.push_back(row);
		for (int k = 1; k < 8; k++) begin
			row.item = mk_load(0, k, 32'h0001_0000 * k, -32'sh0001_0000 * k, 32'h8000_0000);
			dir_rows.push_back(row);
		end
		row.item = mk_load(4095, 7, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		dir_rows.push_back(row);
		row.item = mk_load(4095, 0, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF);
		dir_rows.push_back(row);
		// grid corner, box middle, upper boundary, one LSB inside
		row.item = mk_query(32'h0, 32'h0, 32'h0);
		dir_rows.push_back(row);
		row.item = mk_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		dir_rows.push_back(row);
		row.item = mk_query(32'h000F_0000, 32'h000F_0000, 32'h000F_0000);
		dir_rows.push_back(row);
		row.item = mk_query(32'h000E_FFFF, 32'h0000_0001, 32'h000F_0000);
		dir_rows.push_back(row);
		// off the grid: zeros with in_grid clear
		row.typed = 1'b1;
		row.res = off_grid;
		row.item = mk_query(32'hFFFF_FFFF, 32'h0, 32'h0);
		dir_rows.push_back(row);
		row.item = mk_query(32'h0, 32'h000F_0001, 32'h0);
		dir_rows.push_back(row);
		row.item = mk_query(32'h0, 32'h0, 32'h7FFF_FFFF);
		dir_rows.push_back(row);
		row.item = mk_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		dir_rows.push_back(row);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].item.cmd == thfi_pkg::CMD_LOAD)
				send_load(dir_rows[i].item);
			else
				send_query(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
		end
		drain();

		random_phase(45);

		// offset origin, uneven spacings, scale 1.5
		write_all(32'hFFFC_8000, 32'h0001_4000, 32'hFF9C_0000,
			32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 32'h0001_8000);
		random_phase(45);

		// zero spacing acts as one LSB; largest scale; unknown index dropped
		write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
		write_reg(3'd7, 32'hDEAD_BEEF);
		cfg_valid <= 1'b0;
		@(posedge clk);
		random_phase(45);

		// lowest origin, widest spacing, scale zero
		write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0);
		random_phase(45);

		// highest origin, smallest spacing
		write_all(32'h7FFF_FFFF, 32'h7FFF_FFF0, 32'h7FFF_FF00,
			32'h1, 32'h1, 32'h3, 32'h0001_0000);
		random_phase(45);

		// random moderate settings
		write_all(rand_word(), rand_word(), rand_word(),
			$urandom_range(32'h4000, 32'h40000), $urandom_range(32'h4000, 32'h40000),
			$urandom_range(32'h4000, 32'h40000), $urandom_range(0, 32'h30000));
		random_phase(45);

		if (err_cnt == 0 && field_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#40000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
